// ===== design/tks_pkg.sv =====
// Package for top-k selection: shared types, commands and key mapping.
package tks_pkg;

    localparam int ScoreW = 32;
    localparam int TopKW  = 7;
    localparam int IdW    = 18;

    // Controller to datapath commands.
    typedef struct packed {
        logic start_row;    // sample K, clear count and position
        logic insert;       // insert current element
        logic emit_load;    // load output register from entry emit index
        logic emit_clear;   // reset emit index and row state
    } tks_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic kept_zero;    // no entries kept
        logic emit_last;    // emit index points at last kept entry
    } tks_sts_t;

    // Numeric-order key of a float; NaN lowest, both zeros equal.
    function automatic logic [ScoreW-1:0] order_key(input logic [ScoreW-1:0] bits);
        logic [ScoreW-2:0] mag;
        mag = bits[ScoreW-2:0];
        if (mag > 31'h7F80_0000) begin
            order_key = '0;
        end else if (mag == '0) begin
            order_key = 32'h8000_0000;
        end else if (bits[ScoreW-1]) begin
            order_key = ~bits;
        end else begin
            order_key = bits | 32'h8000_0000;
        end
    endfunction

endpackage

// ===== design/tks_datapath.sv =====
// Datapath: parallel insertion chain of kept pairs and output register.
module tks_datapath #(
    parameter int MAX_K   = 64,
    parameter int ROW_MAX = 262144
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tks_pkg::tks_cmd_t         cmd,
    output tks_pkg::tks_sts_t         sts,
    input  logic [31:0]               score_bits,
    input  logic [6:0]                top_k,
    output logic [17:0]               out_id,
    output logic [31:0]               out_score
);
    import tks_pkg::*;

    localparam int CntW = $clog2(MAX_K + 1);
    localparam int IdxW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int PosW = $clog2(ROW_MAX + 1);

    logic [ScoreW-1:0] score_reg [MAX_K];
    logic [ScoreW-1:0] key_reg   [MAX_K];
    logic [PosW-1:0]   id_reg    [MAX_K];
    logic [CntW-1:0]   kept_reg, kept_next;
    logic [CntW-1:0]   want_reg, want_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [IdxW-1:0]   emit_reg, emit_next;

    logic [ScoreW-1:0] new_key;
    logic [MAX_K-1:0]  below;   // entry i is unused or ranks strictly below new element
    logic [CntW-1:0]   eff_kept, eff_want;
    logic              in_range;

    always_comb begin
        new_key  = order_key(score_bits);
        eff_want = want_reg;
        eff_kept = kept_reg;
        if (cmd.start_row) begin
            eff_kept = '0;
            if (top_k == '0 || top_k > 7'(MAX_K)) begin
                eff_want = CntW'(MAX_K);
            end else begin
                eff_want = CntW'(top_k);
            end
        end
        in_range = cmd.start_row || (pos_reg < PosW'(ROW_MAX));
        for (int i = 0; i < MAX_K; i++) begin
            below[i] = (CntW'(i) >= eff_kept) || (key_reg[i] < new_key);
        end
    end

    // Entry i takes new element if it is the first slot below; shifts if an earlier one is.
    always_ff @(posedge aclk) begin
        if (cmd.insert && in_range) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (CntW'(i) < eff_want && below[i]) begin
                    if (i == 0 || !below[(i > 0) ? i - 1 : 0]) begin
                        score_reg[i] <= score_bits;
                        key_reg[i]   <= new_key;
                        id_reg[i]    <= cmd.start_row ? '0 : pos_reg;
                    end else begin
                        score_reg[i] <= score_reg[(i > 0) ? i - 1 : 0];
                        key_reg[i]   <= key_reg[(i > 0) ? i - 1 : 0];
                        id_reg[i]    <= id_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
        if (cmd.emit_load) begin
            out_id    <= id_reg[emit_reg][IdW-1:0];
            out_score <= score_reg[emit_reg];
        end
    end

    always_comb begin
        kept_next = kept_reg;
        want_next = cmd.start_row ? eff_want : want_reg;
        pos_next  = cmd.start_row ? '0 : pos_reg;
        emit_next = emit_reg;
        if (cmd.insert && in_range) begin
            kept_next = eff_kept;
            // A row not yet full always takes the element somewhere.
            if (eff_kept < eff_want) begin
                kept_next = eff_kept + 1'b1;
            end
            pos_next = (cmd.start_row ? '0 : pos_reg) + 1'b1;
        end
        if (cmd.emit_load) begin
            emit_next = emit_reg + 1'b1;
        end
        if (cmd.emit_clear) begin
            emit_next = '0;
            kept_next = '0;
            pos_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg <= '0;
            want_reg <= '0;
            pos_reg  <= '0;
            emit_reg <= '0;
        end else begin
            kept_reg <= kept_next;
            want_reg <= want_next;
            pos_reg  <= pos_next;
            emit_reg <= emit_next;
        end
    end

    assign sts.kept_zero = (kept_reg == '0);
    assign sts.emit_last = (CntW'(emit_reg) + 1'b1 == kept_reg);

endmodule

// ===== design/tks_ctrl.sv =====
// Controller: row sequencing and pair emission state machine.
module tks_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              row_end,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    output tks_pkg::tks_cmd_t cmd,
    input  tks_pkg::tks_sts_t sts
);
    import tks_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   started_reg, started_next;
    logic   last_reg, last_next;
    logic   s_fire, m_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tlast  = last_reg;

    always_comb begin
        state_next     = state_reg;
        started_next   = started_reg;
        last_next      = last_reg;
        cmd            = '0;
        cmd.start_row  = s_fire && !started_reg;
        cmd.insert     = s_fire;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    started_next = !row_end;
                    if (row_end) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                if (sts.kept_zero) begin
                    cmd.emit_clear = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    cmd.emit_load = 1'b1;
                    last_next     = sts.emit_last;
                    state_next    = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_fire) begin
                    if (last_reg) begin
                        cmd.emit_clear = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            last_reg    <= last_next;
        end
    end

    a_no_accept_while_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during emission");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> s_tready) else $error("no return to idle");
    a_row_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && row_end) |=> (state_reg == ST_LOAD)) else $error("row end lost");

endmodule

// ===== design/top_k_select_stable.sv =====
// Top level of the stable top-k selector over a row of float scores.
// Usage:
//  - s_ channel: one row element per transfer. s_tdata = {top_k[38:32], score_bits[31:0]}
//    (padded to 40 bits), s_tlast = row_end. top_k is sampled on the row's first element;
//    0 or above MAX_K selects MAX_K.
//  - Each element is inserted into a sorted register chain as it is taken (all kept
//    entries compared in parallel), so elements are taken one per cycle within a row.
//  - On the transfer with s_tlast the block stops accepting and emits the kept pairs
//    on the m_ channel, best first: m_tdata = {token_score[49:18], token_id[17:0]},
//    m_tlast = final_pair. Each pair takes an entry read, then an output hold.
//  - Rows shorter than K emit all elements; elements at position ROW_MAX and above
//    are ignored but s_tlast still closes the row.
//  - A stalled receiver holds the current pair in the output register; no input is
//    taken until the last pair is transferred.
//  - Reset (aresetn low, synchronous) clears counters and the state machine; the
//    kept-pair registers are not cleared and need no clearing pass.
module top_k_select_stable #(
    parameter int MAX_K   = 64,
    parameter int ROW_MAX = 262144
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // score_bits[31:0], top_k[38:32], zero pad
    input  logic        s_tlast,   // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // token_id[17:0], token_score[49:18], zero pad
    output logic        m_tlast    // final_pair
);
    import tks_pkg::*;

    tks_cmd_t    cmd;
    tks_sts_t    sts;
    logic [17:0] out_id;
    logic [31:0] out_score;

    tks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .row_end  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    tks_datapath #(
        .MAX_K   (MAX_K),
        .ROW_MAX (ROW_MAX)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .score_bits (s_tdata[31:0]),
        .top_k      (s_tdata[38:32]),
        .out_id     (out_id),
        .out_score  (out_score)
    );

    assign m_tdata = {6'b0, out_score, out_id};

endmodule

// ===== test/tks_checker.sv =====
// Checker for the top-k selector: predicts the kept pairs of each row and compares transfers.
`timescale 1ns / 100ps
module tks_checker #(
    parameter int MAX_K   = 64,
    parameter int ROW_MAX = 262144
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_pairs
);
    typedef struct packed {
        logic [17:0] id;
        logic [31:0] score;
        logic        last;
    } pair_t;

    pair_t pair_q[$];

    logic [31:0] row_scores[MAX_K];
    logic [17:0] row_ids[MAX_K];
    int          row_count;
    int          row_want;
    int          row_pos;
    bit          row_open;

    // Numeric rank: NaN lowest, +0 == -0.
    function automatic logic [31:0] rank_of(input logic [31:0] b);
        if (b[30:0] > 31'h7F80_0000) return 32'h0;
        if (b[30:0] == 31'h0) return 32'h8000_0000;
        if (b[31]) return ~b;
        return b | 32'h8000_0000;
    endfunction

    task automatic absorb_element(input logic [31:0] bits, input logic [6:0] k,
                                  input bit last);
        int slot;
        int top;
        pair_t p;
        if (!row_open) begin
            row_want = (k == 0 || k > MAX_K) ? MAX_K : int'(k);
            row_count = 0;
            row_pos = 0;
            row_open = 1;
        end
        if (row_pos < ROW_MAX) begin
            slot = 0;
            while (slot < row_count && rank_of(row_scores[slot]) >= rank_of(bits))
                slot++;
            if (slot < row_want) begin
                top = (row_count < row_want) ? row_count : row_want - 1;
                for (int i = top; i > slot; i--) begin
                    row_scores[i] = row_scores[i-1];
                    row_ids[i] = row_ids[i-1];
                end
                row_scores[slot] = bits;
                row_ids[slot] = row_pos[17:0];
                if (row_count < row_want) row_count++;
            end
            row_pos++;
        end
        if (last) begin
            for (int i = 0; i < row_count; i++) begin
                p.id    = row_ids[i];
                p.score = row_scores[i];
                p.last  = (i + 1 == row_count);
                pair_q  = {pair_q, p};
            end
            row_count = 0;
            row_pos = 0;
            row_open = 0;
        end
    endtask

    always @(posedge aclk) begin
        pair_t want_p;
        if (!aresetn) begin
            row_open = 0;
            row_count = 0;
            row_pos = 0;
            row_want = 0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_element(s_tdata[31:0], s_tdata[38:32], s_tlast);
            if (m_tvalid && m_tready) begin
                if (pair_q.size() == 0) begin
                    $display("%0t: unexpected pair id=%h score=%h last=%b", $time,
                             m_tdata[17:0], m_tdata[49:18], m_tlast);
                    fail_count++;
                end else begin
                    want_p = pair_q.pop_front();
                    if (want_p.id !== m_tdata[17:0] || want_p.score !== m_tdata[49:18]
                        || want_p.last !== m_tlast) begin
                        $display("%0t: expected id=%h score=%h last=%b, got id=%h score=%h last=%b",
                                 $time, want_p.id, want_p.score, want_p.last,
                                 m_tdata[17:0], m_tdata[49:18], m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending_pairs = pair_q.size();
    end

    initial begin
        fail_count = 0;
        pending_pairs = 0;
    end
endmodule

// ===== test/tb.sv =====
// Testbench top: drives rows of float scores into the top-k selector and gives the verdict.
`timescale 1ns / 100ps
module tb;

    localparam int MAX_K   = 64;
    localparam int ROW_MAX = 262144;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending_pairs;
    int send_idle_pct;      // chance per cycle the sender holds off
    int recv_stall_pct;     // chance per cycle the receiver holds off
    int hold_off_cycles;    // long receiver hold-off, counted in its own process

    top_k_select_stable #(.MAX_K(MAX_K), .ROW_MAX(ROW_MAX)) uut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

    tks_checker #(.MAX_K(MAX_K), .ROW_MAX(ROW_MAX)) chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .fail_count, .pending_pairs
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off when requested.
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 0;
                hold_off_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Interesting score patterns: zeros, infinities, NaNs, extremes, and a
    // small pool so ties are common.
    function automatic logic [31:0] pick_score();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return $urandom_range(1) ? 32'h7F80_0000 : 32'hFF80_0000;
            3: return 32'h7F80_0000 | $urandom_range(1, 32'h7F_FFFF) | ($urandom_range(1) << 31);
            4: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h7F7F_FFFF;
            5, 6: return {$urandom_range(1) == 1,
                          31'(31'h3F80_0000 + ($urandom_range(3) << 23))};
            default: return $urandom();
        endcase
    endfunction

    // One element transfer; waits for the handshake.
    task automatic send_element(input logic [31:0] bits, input logic [6:0] k, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {1'b0, k, bits};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_row(input int len, input logic [6:0] k);
        for (int i = 0; i < len; i++)
            send_element(pick_score(), (i == 0) ? k : 7'($urandom()), i == len - 1);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_pairs != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: single element row, K=1, K=0, K above MAX_K, signed zeros, NaNs.
        send_element(32'h3F80_0000, 7'd0, 1);
        send_element(32'h8000_0000, 7'd2, 0);
        send_element(32'h0000_0000, 7'd0, 0);
        send_element(32'hFF80_0000, 7'd0, 1);
        send_element(32'h7FC0_0000, 7'd1, 0);
        send_element(32'hFFFF_FFFF, 7'd0, 0);
        send_element(32'hFF80_0000, 7'd0, 1);
        send_element(32'h7FC0_0001, 7'd64, 0);
        send_element(32'h7F7F_FFFF, 7'd0, 0);
        send_element(32'h7F80_0000, 7'd0, 0);
        send_element(32'h0000_0001, 7'd0, 0);
        send_element(32'h8000_0001, 7'd0, 1);
        send_element(32'h4000_0000, 7'd127, 0);
        send_element(32'h4000_0000, 7'd0, 0);
        send_element(32'hC000_0000, 7'd0, 1);
        settle();

        // Long receiver hold-off while a big row streams in; the next row is
        // offered at once and waits until the held pairs drain.
        hold_off_cycles = 300;
        send_row(70, 7'd0);
        send_row(5, 7'd3);
        settle();

        // Random rows over the three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 86 : 0;
            recv_stall_pct = (phase == 0) ? 86 : (phase == 1) ? 8 : 0;
            for (int n = 0; n < 105; ) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
                send_row(len, 7'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 8)));
                n += len;
            end
        end
        settle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending_pairs == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
